// ===== design/dkth_pkg.sv =====
// ----------------------------------------------------------------------------
// dkth_pkg: shared types and constants
// Sizes of the value store, the cell grouping and the count widths.
// ----------------------------------------------------------------------------
package dkth_pkg;

	localparam int DEPTH      = 64;              // stored entries, positions 1..DEPTH
	localparam int VALUE_BITS = 30;              // bits kept per entry
	localparam int GROUP      = 8;               // cells chained per group
	localparam int NUM_GROUPS = DEPTH / GROUP;
	localparam int GCNT_W     = $clog2(GROUP + 1);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 7;               // position / bound / rank field width
	localparam int VAL_W      = 30;              // value field width
	localparam int IDX_W      = POS_W + 1;       // room for bound arithmetic

	// action field of an input transfer
	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} dkth_action_t;

	// Broadcast to every cell for one radix step.
	// prefix: bits settled so far (current bit and below are 0)
	// keep:   ones from the MSB down to and including the current bit
	typedef struct packed {
		logic [VALUE_BITS-1:0] prefix;
		logic [VALUE_BITS-1:0] keep;
	} dkth_probe_t;

endpackage

// ===== design/dkth_cell.sv =====
// ----------------------------------------------------------------------------
// dkth_cell: one storage cell
// Holds one entry, flags a prefix match and adds it to the neighbor's count.
// ----------------------------------------------------------------------------
module dkth_cell import dkth_pkg::*; (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic                  in_range,
	input  dkth_probe_t           probe,
	input  logic [GCNT_W-1:0]     count_in,
	output logic [GCNT_W-1:0]     count_out
);

	logic [VALUE_BITS-1:0] value_q;
	logic                  match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_q <= wr_value;
		end
	end

	// prefix has a 0 in the current bit, so this also demands value bit == 0
	assign match     = in_range && (((value_q ^ probe.prefix) & probe.keep) == '0);
	assign count_out = count_in + GCNT_W'(match);

endmodule

// ===== design/dkth_group.sv =====
// ----------------------------------------------------------------------------
// dkth_group: a row of chained cells
// The match count ripples from cell to cell; the last cell gives the group sum.
// ----------------------------------------------------------------------------
module dkth_group import dkth_pkg::*; (
	input  logic                  clk,
	input  logic [GROUP-1:0]      wr_sel,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [GROUP-1:0]      in_range,
	input  dkth_probe_t           probe,
	output logic [GCNT_W-1:0]     count
);

	logic [GCNT_W-1:0] chain [GROUP+1];

	assign chain[0] = '0;

	for (genvar c = 0; c < GROUP; c++) begin : g_cell
		dkth_cell u_cell (
			.clk      (clk),
			.wr_en    (wr_sel[c]),
			.wr_value (wr_value),
			.in_range (in_range[c]),
			.probe    (probe),
			.count_in (chain[c]),
			.count_out(chain[c+1])
		);
	end

	assign count = chain[GROUP];

endmodule

// ===== design/dynamic_range_kth_smallest.sv =====
// Timing: a write transfer is stored at its accepting edge and gives no result. A query
//   with a bad range or rank goes straight to the result load; a valid query first runs a
//   count step and a decide step per value bit, then loads the result.
// Flow: writes every cycle while no query is in flight; after a query the next transfer
//   is accepted once its result has been loaded, later while the result slot is full.
// Reset: arst_n clears control state only; entries are undefined until written.
// ----------------------------------------------------------------------------
// dynamic_range_kth_smallest: k-th smallest value over a position range
// Entries live in a row of cells; a query settles one value bit per count and decide
// step pair by counting prefix matches across all cells in parallel.
// ----------------------------------------------------------------------------
module dynamic_range_kth_smallest import dkth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // position[6:0], new_value[36:7], left_bound[43:37],
	                              // right_bound[50:44], rank[57:51], zeros[63:58]
	input  logic        s_tuser,  // action: 0 = write, 1 = query
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // kth_value[29:0], zeros[31:30]
	output logic        m_tuser   // ok
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_COUNT  = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	// ---- unpack the input transfer ----
	logic             action;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] new_value;
	logic [POS_W-1:0] left_bound;
	logic [POS_W-1:0] right_bound;
	logic [POS_W-1:0] rank;

	assign action      = s_tuser;
	assign position    = s_tdata[6:0];
	assign new_value   = s_tdata[36:7];
	assign left_bound  = s_tdata[43:37];
	assign right_bound = s_tdata[50:44];
	assign rank        = s_tdata[57:51];

	// ---- control and datapath registers ----
	logic [1:0]            state_q;
	logic [POS_W-1:0]      k_q;          // remaining rank
	logic [VALUE_BITS-1:0] prefix_q;     // settled answer bits
	logic [VALUE_BITS-1:0] keep_q;       // MSB..current bit mask
	logic [VALUE_BITS-1:0] cur_bit_q;    // one-hot current bit
	logic                  res_ok_q;
	logic [DEPTH-1:0]      range_q;      // per-cell range membership
	logic [GCNT_W-1:0]     gsum_s1 [NUM_GROUPS];
	logic                  out_valid_q;
	logic [VAL_W-1:0]      out_value_q;
	logic                  out_ok_q;

	logic                  in_xfer;
	logic                  query_good;
	logic [DEPTH-1:0]      wr_sel;
	logic [DEPTH-1:0]      range_next;
	logic [GCNT_W-1:0]     gsum [NUM_GROUPS];
	logic [CNT_W-1:0]      total;
	logic                  take_one;
	dkth_probe_t           probe;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// Range and rank check: 1 <= left <= right <= DEPTH, 1 <= rank <= right-left+1.
	// The rank bound is rewritten as rank + left <= right + 1 to stay unsigned.
	assign query_good = (left_bound != '0)
		&& ({1'b0, right_bound} <= IDX_W'(DEPTH))
		&& (left_bound <= right_bound)
		&& (rank != '0)
		&& (({1'b0, rank} + {1'b0, left_bound}) <= ({1'b0, right_bound} + IDX_W'(1)));

	// Cell select for writes and range mask for queries; cell i is position i+1.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			wr_sel[i]     = in_xfer && (action == ACT_WRITE)
				&& ({1'b0, position} == IDX_W'(i + 1));
			range_next[i] = ({1'b0, left_bound} <= IDX_W'(i + 1))
				&& ({1'b0, right_bound} >= IDX_W'(i + 1));
		end
	end

	assign probe.prefix = prefix_q;
	assign probe.keep   = keep_q;

	// ---- the cell row ----
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		dkth_group u_group (
			.clk     (clk),
			.wr_sel  (wr_sel[g*GROUP +: GROUP]),
			.wr_value(new_value[VALUE_BITS-1:0]),
			.in_range(range_q[g*GROUP +: GROUP]),
			.probe   (probe),
			.count   (gsum[g])
		);
	end

	// Second half of the count: add the registered group sums.
	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			total = total + CNT_W'(gsum_s1[g]);
		end
	end

	// Rank beyond the zero-bit matches: this bit is 1, skip those entries.
	assign take_one = ({1'b0, k_q} > IDX_W'(total));

	// group sums register every cycle; only read in ST_DECIDE
	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			gsum_s1[g] <= gsum[g];
		end
	end

	// query payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && (action == ACT_QUERY)) begin
			k_q       <= rank;
			prefix_q  <= '0;
			cur_bit_q <= {1'b1, {(VALUE_BITS-1){1'b0}}};
			keep_q    <= {1'b1, {(VALUE_BITS-1){1'b0}}};
			range_q   <= range_next;
			res_ok_q  <= query_good;
		end else if (state_q == ST_DECIDE) begin
			if (take_one) begin
				k_q      <= k_q - POS_W'(total);
				prefix_q <= prefix_q | cur_bit_q;
			end
			cur_bit_q <= cur_bit_q >> 1;
			keep_q    <= keep_q | (cur_bit_q >> 1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (action == ACT_QUERY)) begin
						state_q <= query_good ? ST_COUNT : ST_DONE;
					end
				end
				ST_COUNT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= cur_bit_q[0] ? ST_DONE : ST_COUNT;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: loads when the slot is free or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || m_tready)) begin
			out_value_q <= res_ok_q ? VAL_W'(prefix_q) : '0;
			out_ok_q    <= res_ok_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(32-VAL_W){1'b0}}, out_value_q};
	assign m_tuser  = out_ok_q;

	// ---- checks ----
	a_decide_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> $past(state_q) == ST_COUNT)
		else $error("decide step without a preceding count step");

	a_decide_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |=> state_q == ST_COUNT || state_q == ST_DONE)
		else $error("decide step left to an unexpected state");

	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COUNT || state_q == ST_DECIDE |-> $onehot(cur_bit_q))
		else $error("current bit pointer lost its one-hot form");

	a_bad_query_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("rejected query returned a nonzero value");

	a_rank_covered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> k_q != '0)
		else $error("remaining rank dropped to zero during descent");

endmodule
